>>> sv/salc_pkg.sv
// Package for the set-associative LRU cache lookup block.
// Holds geometry constants, the per-line record type and register indexes.
package salc_pkg;
    localparam int WAYS           = 8;
    localparam int SET_INDEX_BITS = 10;
    localparam int NUM_SETS       = 1 << SET_INDEX_BITS;
    localparam int WAY_W          = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W          = (SET_INDEX_BITS > 0) ? SET_INDEX_BITS : 1;
    localparam int AGE_W          = 4;
    localparam int REUSE_W        = 4;
    localparam int TAG_W          = 32;
    localparam int LINE_W         = 1 + TAG_W + AGE_W + REUSE_W;
    localparam int SET_REC_W      = LINE_W * WAYS;
    localparam int BUCKETS        = 16;
    localparam logic [REUSE_W-1:0] REUSE_MAX = 4'd15;
    localparam logic [AGE_W-1:0]   AGE_OLD   = AGE_W'(WAYS - 1);

    localparam logic [0:0] REG_OFFSET_BITS = 1'b0;
    localparam logic [0:0] REG_INDEX_BITS  = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [TAG_W-1:0]  tag;
        logic [AGE_W-1:0]  age;
        logic [REUSE_W-1:0] reuse;
    } t_line;
endpackage

>>> sv/salc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> sv/set_assoc_lru_cache_lookup_top.sv
// Set-associative cache lookup with per-line LRU ages and reuse histogram.
// Depends on salc_pkg and salc_ram.
//
// Usage:
//   Input channel (i_valid/o_ready, i_address) takes one byte address per
//   transfer. Output channel (o_valid/i_ready) returns one result per access:
//   hit flag, way, eviction data, bucket total and the running counters.
//   Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   offset_bits (index 0) and index_bits (index 1); write only while idle.
//   Per access: the set record is read from the set RAM from the accepting
//   edge; in S_READ all ways are compared in parallel, ages are updated,
//   the set is written back and the result is registered into the output
//   register, held in S_OUT. One item is in flight at a time.
//   Reset: a clearing pass writes zeros to all NUM_SETS (1024) sets, one set
//   per cycle; during the pass no address is accepted, and config writes
//   are taken throughout. Histogram and counters clear at once.
//   Stall: while the result waits for i_ready the block accepts no new item.
module set_assoc_lru_cache_lookup_top
    import salc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_address,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_hit,
    output logic [2:0]  o_way,
    output logic        o_evicted,
    output logic [3:0]  o_evicted_reuse,
    output logic [31:0] o_bucket_total,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total,
    output logic [31:0] o_access_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [SET_W:0]      r_clr, n_clr;
    logic [4:0]          r_off;
    logic [3:0]          r_ib;
    logic [SET_W-1:0]    r_set;
    logic [TAG_W-1:0]    r_tag;
    logic [31:0]         r_hist [BUCKETS];
    logic [31:0]         r_hits, r_miss, r_acc;

    logic                ram_we;
    logic [SET_W-1:0]    ram_waddr, ram_raddr;
    logic [SET_REC_W-1:0] ram_wdata, ram_rdata;

    salc_ram #(.WIDTH(SET_REC_W), .DEPTH(NUM_SETS)) u_set_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = (r_state == S_OUT);

    // Address split: clamp index width, shift, mask.
    logic [3:0]  ib;
    logic [31:0] shifted;
    logic [SET_W-1:0] set_now;
    assign ib      = (r_ib > 4'(SET_INDEX_BITS)) ? 4'(SET_INDEX_BITS) : r_ib;
    assign shifted = i_address >> r_off;
    assign set_now = SET_W'(shifted & ((32'd1 << ib) - 32'd1));

    // Start the set read at the accepting edge so the record is there in S_READ.
    assign ram_raddr = (r_state == S_IDLE) ? set_now : r_set;

    // Per-way lookup and update on the read record.
    t_line lines [WAYS];
    t_line nlines [WAYS];
    logic [WAYS-1:0] hv, vq;
    logic            hit;
    logic [WAY_W-1:0] hw, vw, sel;
    logic [AGE_W-1:0] hit_age;
    logic            ev;
    logic [REUSE_W-1:0] ev_reuse;

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            lines[w] = t_line'(ram_rdata[w*LINE_W +: LINE_W]);
            hv[w] = lines[w].valid && (lines[w].tag == r_tag);
            vq[w] = !lines[w].valid || (lines[w].age == AGE_OLD);
        end
        hit = |hv;
        hw = '0;
        for (int w = WAYS - 1; w >= 0; w--) if (hv[w]) hw = WAY_W'(w);
        vw = '0;
        for (int w = WAYS - 1; w >= 0; w--) if (vq[w]) vw = WAY_W'(w);
        sel      = hit ? hw : vw;
        hit_age  = lines[hw].age;
        ev       = !hit && lines[vw].valid;
        ev_reuse = lines[vw].reuse;
        for (int w = 0; w < WAYS; w++) begin
            nlines[w] = lines[w];
            if (WAY_W'(w) == sel) begin
                nlines[w].age = '0;
                if (hit) begin
                    if (lines[w].reuse < REUSE_MAX) nlines[w].reuse = lines[w].reuse + 1'b1;
                end else begin
                    nlines[w].valid = 1'b1;
                    nlines[w].tag   = r_tag;
                    nlines[w].reuse = '0;
                end
            end else if (lines[w].valid && (!hit || lines[w].age < hit_age)) begin
                nlines[w].age = lines[w].age + 1'b1;
            end
        end
        for (int w = 0; w < WAYS; w++) ram_wdata[w*LINE_W +: LINE_W] = nlines[w];
        if (r_state == S_CLEAR) ram_wdata = '0;
    end

    assign ram_we    = (r_state == S_CLEAR) || (r_state == S_READ);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr[SET_W-1:0] : r_set;

    always_comb begin
        n_state = r_state;
        n_clr   = r_clr;
        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == (SET_W+1)'(NUM_SETS - 1)) n_state = S_IDLE;
            end
            S_IDLE:  if (i_valid) n_state = S_READ;
            S_READ:  n_state = S_OUT;
            S_OUT:   if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_off   <= 5'd6;
            r_ib    <= 4'd10;
            r_hits  <= '0;
            r_miss  <= '0;
            r_acc   <= '0;
            for (int b = 0; b < BUCKETS; b++) r_hist[b] <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_OFFSET_BITS) r_off <= i_cfg_data[4:0];
                else r_ib <= i_cfg_data[3:0];
            end
            if (r_state == S_READ) begin
                r_acc <= r_acc + 1'b1;
                if (hit) r_hits <= r_hits + 1'b1;
                else r_miss <= r_miss + 1'b1;
                if (ev) r_hist[ev_reuse] <= r_hist[ev_reuse] + 1'b1;
            end
        end
    end

    // Capture address fields and the result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_set <= set_now;
            r_tag <= shifted >> ib;
        end
        if (r_state == S_READ) begin
            o_hit           <= hit;
            o_way           <= 3'(sel);
            o_evicted       <= ev;
            o_evicted_reuse <= ev ? ev_reuse : '0;
            o_bucket_total  <= ev ? r_hist[ev_reuse] + 32'd1 : '0;
            o_hit_total     <= r_hits + (hit ? 32'd1 : 32'd0);
            o_miss_total    <= r_miss + (hit ? 32'd0 : 32'd1);
            o_access_total  <= r_acc + 32'd1;
        end
    end
endmodule
